// ----- rtl/edf_pkg.sv -----
// ============================================================================
// edf_pkg
// Shared types and constants for the earliest-deadline-first tick scheduler.
// ============================================================================
package edf_pkg;

    localparam int MAX_TASKS   = 4;
    localparam int NUM_TASKS   = 4;
    localparam int HYPERPERIOD = 910;

    localparam int TASK_W  = $clog2(MAX_TASKS);
    localparam int VAL_W   = 8;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = $clog2(2 * MAX_TASKS);
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);
    localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(HYPERPERIOD - 1);

    typedef logic [VAL_W-1:0] t_val;

    localparam t_val PERIOD_RST [MAX_TASKS] = '{8'd2, 8'd5, 8'd7, 8'd13};
    localparam t_val BUDGET_RST [MAX_TASKS] = '{8'd1, 8'd1, 8'd1, 8'd2};

    typedef struct packed {
        t_val period;
        t_val budget;
        t_val deadline;
        t_val work;
    } t_task_view;

    typedef struct packed {
        logic              en;
        logic [TASK_W-1:0] idx;
        t_val              deadline;
        t_val              work;
    } t_task_wr;

    typedef struct packed {
        logic       feasible;
        logic       period_end;
        logic       any_miss;
        logic [1:0] miss_task;
        logic       miss;
        logic       idle;
        logic [1:0] run_task;
    } t_result;

endpackage

// ----- rtl/edf_task_file.sv -----
// ============================================================================
// edf_task_file
// Configuration registers and per-task deadline and budget counters, with
// one read port and one write port addressed by task index.
// ============================================================================
module edf_task_file (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [edf_pkg::CFG_W-1:0]  i_cfg_idx,
    input  logic [edf_pkg::VAL_W-1:0]  i_cfg_data,
    input  logic [edf_pkg::TASK_W-1:0] i_rd_idx,
    output edf_pkg::t_task_view        o_view,
    input  edf_pkg::t_task_wr          i_wr
);

    edf_pkg::t_val r_period   [edf_pkg::MAX_TASKS];
    edf_pkg::t_val r_budget   [edf_pkg::MAX_TASKS];
    edf_pkg::t_val r_deadline [edf_pkg::MAX_TASKS];
    edf_pkg::t_val r_work     [edf_pkg::MAX_TASKS];

    logic [edf_pkg::TASK_W-1:0] cfg_task;
    logic                       cfg_is_budget;

    assign cfg_task      = i_cfg_idx[edf_pkg::TASK_W-1:0];
    assign cfg_is_budget = i_cfg_idx[edf_pkg::CFG_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < edf_pkg::MAX_TASKS; i++) begin
                r_period[i] <= edf_pkg::PERIOD_RST[i];
                r_budget[i] <= edf_pkg::BUDGET_RST[i];
            end
        end else if (i_cfg_we) begin
            if (cfg_is_budget) begin
                r_budget[cfg_task] <= i_cfg_data;
            end else begin
                r_period[cfg_task] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < edf_pkg::MAX_TASKS; i++) begin
                r_deadline[i] <= '0;
                r_work[i]     <= '0;
            end
        end else if (i_wr.en) begin
            r_deadline[i_wr.idx] <= i_wr.deadline;
            r_work[i_wr.idx]     <= i_wr.work;
        end
    end

    assign o_view.period   = r_period[i_rd_idx];
    assign o_view.budget   = r_budget[i_rd_idx];
    assign o_view.deadline = r_deadline[i_rd_idx];
    assign o_view.work     = r_work[i_rd_idx];

endmodule

// ----- rtl/edf_ctrl.sv -----
// ============================================================================
// edf_ctrl
// Sequencer that walks the tasks one per cycle through a shared compare and
// decrement unit: scan picks the grant (not on restart), update applies it.
// ============================================================================
module edf_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_restart,
    output logic                       o_in_ready,
    output logic [edf_pkg::TASK_W-1:0] o_rd_idx,
    input  edf_pkg::t_task_view        i_view,
    output edf_pkg::t_task_wr          o_wr,
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output edf_pkg::t_result           o_res
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                 r_state,    n_state;
    logic [edf_pkg::TASK_W-1:0] r_idx,      n_idx;
    logic                       r_restart,  n_restart;
    logic                       r_found,    n_found;
    logic [edf_pkg::TASK_W-1:0] r_best,     n_best;
    edf_pkg::t_val              r_best_dl,  n_best_dl;
    logic                       r_missed,   n_missed;
    logic [edf_pkg::TASK_W-1:0] r_miss_idx, n_miss_idx;
    logic                       r_miss_seen, n_miss_seen;
    logic [edf_pkg::TICK_W-1:0] r_tick,     n_tick;

    logic          is_last;
    logic          dl_lt_best;
    logic          dl_expire;
    logic          spend;
    edf_pkg::t_val work_next;
    edf_pkg::t_val dl_dec;
    logic          wrap;
    logic          seen_next;

    assign is_last    = (r_idx == edf_pkg::LAST_TASK);
    assign dl_lt_best = (i_view.deadline < r_best_dl);
    assign dl_expire  = (i_view.deadline <= edf_pkg::VAL_W'(1));
    assign spend      = r_found && (r_best == r_idx);
    assign work_next  = i_view.work - edf_pkg::VAL_W'(spend);
    assign dl_dec     = i_view.deadline - edf_pkg::VAL_W'(1);
    assign wrap       = !r_restart && (r_tick == edf_pkg::LAST_TICK);
    assign seen_next  = !r_restart && (r_miss_seen || r_missed);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_restart   = r_restart;
        n_found     = r_found;
        n_best      = r_best;
        n_best_dl   = r_best_dl;
        n_missed    = r_missed;
        n_miss_idx  = r_miss_idx;
        n_miss_seen = r_miss_seen;
        n_tick      = r_tick;
        o_wr        = '0;
        o_wr.idx    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx      = '0;
                    n_restart  = i_in_restart;
                    n_found    = 1'b0;
                    n_best     = '0;
                    n_best_dl  = '0;
                    n_missed   = 1'b0;
                    n_miss_idx = '0;
                    n_state    = i_in_restart ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_view.work != '0 && (!r_found || dl_lt_best)) begin
                    n_found   = 1'b1;
                    n_best    = r_idx;
                    n_best_dl = i_view.deadline;
                end
                if (is_last) begin
                    n_idx   = '0;
                    n_state = S_UPDATE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_UPDATE: begin
                o_wr.en = 1'b1;
                if (r_restart || dl_expire) begin
                    o_wr.deadline = i_view.period;
                    o_wr.work     = i_view.budget;
                    if (!r_restart && work_next != '0 && !r_missed) begin
                        n_missed   = 1'b1;
                        n_miss_idx = r_idx;
                    end
                end else begin
                    o_wr.deadline = dl_dec;
                    o_wr.work     = work_next;
                end
                if (is_last) begin
                    n_state = S_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FINISH: begin
                if (i_res_take) begin
                    n_miss_seen = seen_next;
                    n_tick      = (r_restart || wrap) ? '0 : r_tick + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_restart   <= 1'b0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_best_dl   <= '0;
            r_missed    <= 1'b0;
            r_miss_idx  <= '0;
            r_miss_seen <= 1'b0;
            r_tick      <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_restart   <= n_restart;
            r_found     <= n_found;
            r_best      <= n_best;
            r_best_dl   <= n_best_dl;
            r_missed    <= n_missed;
            r_miss_idx  <= n_miss_idx;
            r_miss_seen <= n_miss_seen;
            r_tick      <= n_tick;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_rd_idx    = r_idx;
    assign o_res_valid = (r_state == S_FINISH);

    always_comb begin
        o_res            = '0;
        o_res.run_task   = 2'(r_best);
        o_res.idle       = !r_restart && !r_found;
        o_res.miss       = r_missed;
        o_res.miss_task  = 2'(r_miss_idx);
        o_res.any_miss   = seen_next;
        o_res.period_end = wrap;
        o_res.feasible   = wrap && !seen_next;
    end

endmodule

// ----- rtl/edf_tick_scheduler.sv -----
// ============================================================================
// edf_tick_scheduler
// Earliest-deadline-first tick scheduler for up to four periodic tasks.
// ============================================================================
// Usage:
//   The slave stream carries one item per transfer; tdata bit 0 is restart
//   (1 reloads every task and clears the tick counter and sticky miss flag,
//   0 advances one scheduler tick). The master stream returns one result per
//   input. The user must write periods and budgets through the cfg port
//   only while idle; the block itself does not enforce this. Each tick walks
//   the tasks through a single shared compare and decrement unit: a scan
//   pass finds the grant, an update pass applies it, and a finish state
//   hands the result to the output register; a restart skips the scan pass.
//   The next input is taken only after the finish state, and the result
//   shows up on the master side in the same cycle that the slave side
//   becomes ready again. The output register lets the next input be taken
//   while a result still waits; if the receiver stalls until the next result
//   is ready, that result is held inside and the slave side stays not ready.
//   After reset all deadlines and remaining work are zero, so issue a restart
//   before the first tick; configuration registers reset to their defaults.
// ============================================================================
module edf_tick_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [0] restart, [7:1] zero
    input  logic [edf_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [1:0] run_task, [2] idle, [3] miss, [5:4] miss_task, [6] any_miss,
    // [7] period_end, [8] feasible, [15:9] zero
    output logic [edf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [edf_pkg::CFG_W-1:0]       i_cfg_idx,
    input  logic [edf_pkg::VAL_W-1:0]       i_cfg_data
);

    logic [edf_pkg::TASK_W-1:0] rd_idx;
    edf_pkg::t_task_view        view;
    edf_pkg::t_task_wr          wr;
    edf_pkg::t_result           res;
    logic                       res_valid;
    logic                       res_take;

    logic             r_out_valid;
    edf_pkg::t_result r_out;

    edf_task_file u_task_file (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rd_idx   (rd_idx),
        .o_view     (view),
        .i_wr       (wr)
    );

    edf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_restart (i_s_axis_tdata[0]),
        .o_in_ready   (o_s_axis_tready),
        .o_rd_idx     (rd_idx),
        .i_view       (view),
        .o_wr         (wr),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    assign res_take = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = edf_pkg::OUT_TDATA_W'(r_out);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("scheduler took a second item while busy");

    a_idle_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> o_m_axis_tdata[1:0] == 2'd0)
        else $error("idle result carries a task index");

    a_miss_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |-> o_m_axis_tdata[6])
        else $error("miss reported without sticky flag");

    a_feasible_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[8] |-> o_m_axis_tdata[7] && !o_m_axis_tdata[6])
        else $error("feasible outside period end or after a miss");

endmodule
